// File: sv/hsec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_pkg: shared types and constants of the Hamming codec
// Codeword geometry, request and result codes, and the parity coverage masks.
// ----------------------------------------------------------------------------
package hsec_pkg;

  // Codeword width in bits (position p sits in bit p-1).
  localparam int unsigned CW_W  = 63;
  // Width of a position, a syndrome and the data-width register.
  localparam int unsigned POS_W = 6;

  typedef logic [CW_W-1:0]  word_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BEYOND    = 2'd2
  } status_t;

  // Active codeword geometry derived from the data-width register.
  typedef struct packed {
    pos_t  m;     // effective data bit count
    pos_t  n;     // codeword length
    word_t mask;  // ones at positions 1..n
  } geom_t;

  // Positions whose index has bit i set.
  function automatic word_t cover_mask(input int unsigned i);
    word_t c;
    c = '0;
    for (int unsigned k = 0; k < CW_W; k++) begin
      c[k] = 1'((k + 1) >> i);
    end
    return c;
  endfunction

  // Syndrome: XOR of the indices of all set positions, one parity tree per bit.
  function automatic pos_t syndrome(input word_t w);
    pos_t s;
    s = '0;
    for (int unsigned i = 0; i < POS_W; i++) begin
      s[i] = ^(w & cover_mask(i));
    end
    return s;
  endfunction

  // Data bit index carried at codeword bit k (position k+1, not a power of two).
  function automatic int unsigned data_slot(input int unsigned k);
    int unsigned pows;
    pows = 0;
    for (int unsigned i = 0; i < POS_W; i++) begin
      if ((1 << i) <= (k + 1)) pows++;
    end
    return k - pows;
  endfunction

  function automatic bit is_pow2(input int unsigned p);
    return (p & (p - 1)) == 0;
  endfunction

endpackage

// File: sv/hsec_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_req_if: request channel of the Hamming codec
// Valid/ready channel carrying the operation kind and the input word.
// ----------------------------------------------------------------------------
interface hsec_req_if;
  import hsec_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  word_t word_in;

  modport source (output valid, output kind, output word_in, input ready);
  modport sink   (input valid, input kind, input word_in, output ready);
endinterface

// File: sv/hsec_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_res_if: result channel of the Hamming codec
// Valid/ready channel carrying the codeword, the syndrome and the status.
// ----------------------------------------------------------------------------
interface hsec_res_if;
  import hsec_pkg::*;

  logic    valid;
  logic    ready;
  word_t   word_out;
  pos_t    error_position;
  status_t status;

  modport source (output valid, output word_out, output error_position, output status,
                  input ready);
  modport sink   (input valid, input word_out, input error_position, input status,
                  output ready);
endinterface

// File: sv/hsec_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_cfg: data-width register and codeword geometry
// Holds the data-width register and derives the effective m, n and mask.
// ----------------------------------------------------------------------------
module hsec_cfg #(
  parameter int unsigned MAX_DATA_BITS = 57
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  hsec_pkg::pos_t     wdata,
  output hsec_pkg::geom_t    geom
);
  import hsec_pkg::*;

  localparam pos_t MAX_M = pos_t'(MAX_DATA_BITS);
  localparam pos_t RESET_M = pos_t'(4);

  pos_t data_bits;
  pos_t m_eff;
  pos_t r_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits <= RESET_M;
    end else if (we) begin
      data_bits <= wdata;
    end
  end

  always_comb begin
    priority if (data_bits == '0) begin
      m_eff = pos_t'(1);
    end else if (data_bits > MAX_M) begin
      m_eff = MAX_M;
    end else begin
      m_eff = data_bits;
    end

    // Least r with 2^r >= m + r + 1.
    priority if (m_eff <= pos_t'(1)) begin
      r_cnt = pos_t'(2);
    end else if (m_eff <= pos_t'(4)) begin
      r_cnt = pos_t'(3);
    end else if (m_eff <= pos_t'(11)) begin
      r_cnt = pos_t'(4);
    end else if (m_eff <= pos_t'(26)) begin
      r_cnt = pos_t'(5);
    end else begin
      r_cnt = pos_t'(6);
    end

    geom.m = m_eff;
    geom.n = m_eff + r_cnt;
    for (int unsigned k = 0; k < CW_W; k++) begin
      geom.mask[k] = (POS_W'(k) < geom.n);
    end
  end

endmodule

// File: sv/hsec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_core: Hamming encode and check-and-correct datapath
// Combinational data spreading, parity trees and single-bit correction.
// ----------------------------------------------------------------------------
module hsec_core (
  input  hsec_pkg::kind_t   kind,
  input  hsec_pkg::word_t   word_in,
  input  hsec_pkg::geom_t   geom,
  output hsec_pkg::word_t   word_out,
  output hsec_pkg::pos_t    error_position,
  output hsec_pkg::status_t status
);
  import hsec_pkg::*;

  word_t spread;
  word_t enc_word;
  pos_t  enc_syn;
  word_t rx_word;
  pos_t  dec_syn;
  word_t flip;

  // Data bit j lands on the j-th position that is not a power of two.
  for (genvar k = 0; k < CW_W; k++) begin : g_spread
    if (is_pow2(k + 1)) begin : g_par
      assign spread[k] = 1'b0;
    end else begin : g_dat
      localparam int unsigned J = data_slot(k);
      assign spread[k] = word_in[J] & (POS_W'(J) < geom.m);
    end
  end

  always_comb begin
    enc_syn  = syndrome(spread);
    enc_word = spread;
    for (int unsigned i = 0; i < POS_W; i++) begin
      enc_word[(1 << i) - 1] = enc_syn[i];
    end

    rx_word = word_in & geom.mask;
    dec_syn = syndrome(rx_word);
    for (int unsigned k = 0; k < CW_W; k++) begin
      flip[k] = (dec_syn == POS_W'(k + 1));
    end

    unique case (kind)
      KIND_ENCODE: begin
        word_out       = enc_word & geom.mask;
        error_position = '0;
        status         = ST_OK;
      end
      KIND_DECODE: begin
        error_position = dec_syn;
        priority if (dec_syn == '0) begin
          word_out = rx_word;
          status   = ST_OK;
        end else if (dec_syn <= geom.n) begin
          word_out = (rx_word ^ flip) & geom.mask;
          status   = ST_CORRECTED;
        end else begin
          word_out = rx_word;
          status   = ST_BEYOND;
        end
      end
      default: begin
        word_out       = '0;
        error_position = '0;
        status         = ST_OK;
      end
    endcase
  end

endmodule

// File: sv/hamming_single_error_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_single_error_codec: single-error-correcting Hamming codec
// Encodes data words into Hamming codewords of configurable length, or checks
// a received codeword, corrects one flipped bit and reports the syndrome.
// ----------------------------------------------------------------------------
//
//   Channel    Dir   Handshake      Payload
//   req        in    valid/ready    kind, word_in
//   res        out   valid/ready    word_out, error_position, status
//   data_bits  in    write enable   data_bits_wdata (6 bits)
//
// Each request passes first through the input register and then through
// the result register. With res.ready held high a request is taken in
// every cycle; the codeword parity trees sit between the two registers.
// While a result waits on res.ready, a new request is still taken into the
// input register; only when both stages are full does req.ready drop.
// Reset (rst, synchronous) empties both stages and sets data_bits to 4,
// which gives a seven-bit codeword.
//
module hamming_single_error_codec #(
  parameter int unsigned MAX_DATA_BITS = 57
) (
  input  logic           clk,
  input  logic           rst,
  hsec_req_if.sink       req,
  hsec_res_if.source     res,
  input  logic           data_bits_we,
  input  hsec_pkg::pos_t data_bits_wdata
);
  import hsec_pkg::*;

  // Geometry follows the data-width register; the user, not the block, must
  // change it only while the block is empty, so each request sees one geometry.
  geom_t geom;

  hsec_cfg #(
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (data_bits_we),
    .wdata (data_bits_wdata),
    .geom  (geom)
  );

  // Input register stage.
  logic  in_valid;
  kind_t in_kind;
  word_t in_word;

  // Result register stage.
  logic    out_valid;
  word_t   out_word;
  pos_t    out_pos;
  status_t out_status;

  // Combinational result of the request in the input register.
  word_t   core_word;
  pos_t    core_pos;
  status_t core_status;

  logic out_load;
  logic in_load;

  // The result register takes a new value whenever it is empty or its
  // current value leaves this cycle.
  assign out_load  = !out_valid || res.ready;
  assign in_load   = !in_valid || out_load;
  assign req.ready = in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && req.valid) begin
      in_kind <= req.kind;
      in_word <= req.word_in;
    end
  end

  hsec_core u_core (
    .kind           (in_kind),
    .word_in        (in_word),
    .geom           (geom),
    .word_out       (core_word),
    .error_position (core_pos),
    .status         (core_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_word   <= core_word;
      out_pos    <= core_pos;
      out_status <= core_status;
    end
  end

  assign res.valid          = out_valid;
  assign res.word_out       = out_word;
  assign res.error_position = out_pos;
  assign res.status         = out_status;

  // A clean result reports a zero syndrome, and a correction or an
  // out-of-range syndrome always reports a nonzero one.
  a_status_vs_syndrome: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ((res.status == ST_OK) == (res.error_position == '0)))
    else $error("status does not agree with the reported syndrome");

  // No codeword bit beyond the configured length ever leaves the block.
  a_word_in_length: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ((res.word_out & ~geom.mask) == '0))
    else $error("result word has bits beyond the codeword length");

  // A request held in the input register while the result stalls is kept.
  a_stall_keeps_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_load) |=> in_valid)
    else $error("request dropped from the input register during a stall");

  // A correction names a position inside the codeword.
  a_correct_in_range: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_CORRECTED) |-> (res.error_position <= geom.n))
    else $error("corrected position lies beyond the codeword length");

endmodule

// File: tb/tb_hamming_single_error_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_single_error_codec: self-checking bench for the Hamming codec
// Drives encode and decode requests under several data widths with random
// gaps on both channels, predicts every result in the bench itself and
// compares each returned codeword, syndrome and status in order.
// ----------------------------------------------------------------------------
module tb_hamming_single_error_codec;
  import hsec_pkg::*;

  localparam int unsigned MAX_DATA_BITS = 57;

  // Expected outcome of one request.
  typedef struct {
    word_t   word;
    pos_t    syn;
    status_t status;
  } codec_result_t;

  // The scoreboard keeps its own copy of the data-width register, turns each
  // accepted request into the result the codec should return, and checks the
  // returned results in arrival order.
  class codec_scoreboard;
    pos_t          width_reg;
    codec_result_t pending_results[$];
    int unsigned   errors;

    function new();
      width_reg = 6'd4;
      errors    = 0;
    endfunction

    task report(input string msg);
      errors++;
      // Keep the log readable when the block is badly broken.
      if (errors <= 100) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Codeword length for a register value, with the register saturated to
    // the supported range of data widths.
    function int unsigned codeword_length(input pos_t reg_val);
      int unsigned m;
      int unsigned r;
      m = reg_val;
      if (m < 1) m = 1;
      if (m > MAX_DATA_BITS) m = MAX_DATA_BITS;
      r = 0;
      while ((1 << r) < m + r + 1) r++;
      return m + r;
    endfunction

    function word_t codeword_mask(input int unsigned n);
      word_t mask;
      mask = '0;
      for (int unsigned p = 0; p < n; p++) mask[p] = 1'b1;
      return mask;
    endfunction

    // XOR of the indices of all set positions among 1..n.
    function int unsigned index_xor(input word_t w, input int unsigned n);
      int unsigned s;
      s = 0;
      for (int unsigned p = 1; p <= n; p++) begin
        if (w[p-1]) s ^= p;
      end
      return s;
    endfunction

    function codec_result_t predict_codec(input pos_t reg_val, input kind_t kind,
                                          input word_t w);
      codec_result_t res;
      int unsigned   n;
      int unsigned   j;
      int unsigned   s;
      word_t         cw;
      n  = codeword_length(reg_val);
      cw = '0;
      res.syn    = '0;
      res.status = ST_OK;
      if (kind == KIND_ENCODE) begin
        // Data bits go to the positions that are not powers of two.
        j = 0;
        for (int unsigned p = 1; p <= n; p++) begin
          if ((p & (p - 1)) != 0) begin
            cw[p-1] = w[j];
            j++;
          end
        end
        // Each parity bit at 2^i evens out the positions with bit i set.
        s = index_xor(cw, n);
        for (int unsigned i = 0; i < POS_W; i++) begin
          if (((1 << i) <= n) && s[i]) cw[(1 << i) - 1] = 1'b1;
        end
      end else begin
        cw = w & codeword_mask(n);
        s  = index_xor(cw, n);
        res.syn = pos_t'(s);
        if (s == 0) begin
          res.status = ST_OK;
        end else if (s <= n) begin
          cw[s-1]    = ~cw[s-1];
          res.status = ST_CORRECTED;
        end else begin
          // The syndrome names a position past the end: leave the word alone.
          res.status = ST_BEYOND;
        end
      end
      res.word = cw & codeword_mask(n);
      return res;
    endfunction

    function void note_request(input kind_t kind, input word_t w);
      pending_results.push_back(predict_codec(width_reg, kind, w));
    endfunction

    task check_result(input word_t w, input pos_t syn, input status_t status);
      codec_result_t exp_res;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h with no request outstanding", w));
      end else begin
        exp_res = pending_results.pop_front();
        if (w !== exp_res.word)
          report($sformatf("word_out %h, expected %h", w, exp_res.word));
        if (syn !== exp_res.syn)
          report($sformatf("error_position %0d, expected %0d", syn, exp_res.syn));
        if (status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", status, exp_res.status));
      end
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  data_bits_we;
  pos_t  data_bits_wdata;
  // When set, neither side inserts gaps, so requests stream back to back.
  bit    calm;

  codec_scoreboard sb;

  hsec_req_if req_ch ();
  hsec_res_if res_ch ();

  hamming_single_error_codec #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .res            (res_ch),
    .data_bits_we   (data_bits_we),
    .data_bits_wdata(data_bits_wdata)
  );

  always #2 clk = ~clk;

  // Random 63-bit word; every bit is equally likely to be set.
  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  // Number of idle cycles before the next request or result. About half of
  // the draws are zero so that back-to-back traffic also shows up.
  function automatic int unsigned draw_gap();
    if (calm || ($urandom_range(0, 1) == 0)) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Presents one request, starting at a falling edge, and returns at the
  // falling edge after it was accepted. The valid line is only lowered when
  // a gap is drawn, so consecutive requests never toggle it within a step.
  task automatic send_request(input kind_t kind, input word_t w);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.word_in <= w;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, w);
    @(negedge clk);
  endtask

  // Stops the request stream until every outstanding result has come back,
  // then lets the two pipeline stages settle.
  task automatic drain_codec();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Width changes happen only with the codec empty.
  task automatic write_data_bits(input pos_t value);
    drain_codec();
    data_bits_we    <= 1'b1;
    data_bits_wdata <= value;
    @(negedge clk);
    data_bits_we    <= 1'b0;
    sb.width_reg = value;
  endtask

  // Mostly well-formed traffic: fresh data to encode, or a valid codeword
  // under the current width with zero, one or two flipped bits and random
  // junk above the codeword. The rest is raw noise on the decode side.
  task automatic random_request();
    int unsigned   n;
    int unsigned   pick;
    int unsigned   flip;
    word_t         cw;
    codec_result_t enc;
    n    = sb.codeword_length(sb.width_reg);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      send_request(KIND_ENCODE, rand_word());
    end else if (pick < 9) begin
      enc = sb.predict_codec(sb.width_reg, KIND_ENCODE, rand_word());
      cw  = enc.word;
      if (pick >= 5) begin
        flip = $urandom_range(1, n);
        cw[flip-1] = ~cw[flip-1];
      end
      // A second flip usually gives a syndrome that is wrong or out of range.
      if (pick == 8) begin
        flip = $urandom_range(1, n);
        cw[flip-1] = ~cw[flip-1];
      end
      if ($urandom_range(0, 1) == 1) cw = cw | (rand_word() & ~sb.codeword_mask(n));
      send_request(KIND_DECODE, cw);
    end else begin
      send_request(KIND_DECODE, rand_word());
    end
  endtask

  // Result side: holds ready low for a random stall before each result, and
  // keeps it high across results when no stall is drawn.
  initial begin : result_sink
    int unsigned stall;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      sb.check_result(res_ch.word_out, res_ch.error_position, res_ch.status);
      @(negedge clk);
    end
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin : watchdog
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    word_t       ones;
    pos_t        phase_widths [12];
    int unsigned n_items;
    sb   = new();
    ones = '1;
    phase_widths = '{6'd0, 6'd1, 6'd57, 6'd63, 6'd2, 6'd3,
                     6'd5, 6'd58, 6'd11, 6'd26, 6'd33, 6'd4};

    rst             = 1'b1;
    calm            = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.kind     = KIND_ENCODE;
    req_ch.word_in  = '0;
    res_ch.ready    = 1'b0;
    data_bits_we    = 1'b0;
    data_bits_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, first at the reset width of four data bits (n = 7).
    send_request(KIND_ENCODE, '0);
    // All input bits set: everything above the four data bits is ignored.
    send_request(KIND_ENCODE, ones);
    send_request(KIND_ENCODE, word_t'(63'h5A5A_0000_0000_000A));
    send_request(KIND_DECODE, '0);
    // All ones: the seven positions form a valid word, the rest is dropped.
    send_request(KIND_DECODE, ones);
    // Single flips on two parity positions and on the last one, a data position.
    send_request(KIND_DECODE, word_t'(63'h1));
    send_request(KIND_DECODE, word_t'(63'h8));
    send_request(KIND_DECODE, word_t'(63'h40));

    // Five data bits give n = 9, so syndromes 10 to 15 point past the end.
    write_data_bits(6'd5);
    send_request(KIND_DECODE, word_t'(63'h82));
    send_request(KIND_DECODE, word_t'(63'h100));
    send_request(KIND_ENCODE, ones);

    // Widest codeword: all 63 positions in use.
    write_data_bits(6'd57);
    send_request(KIND_ENCODE, ones);
    send_request(KIND_DECODE, ones);
    send_request(KIND_DECODE, word_t'(63'h4000_0000_0000_0000));
    send_request(KIND_ENCODE, '0);

    // A width of zero behaves as one data bit.
    write_data_bits(6'd0);
    send_request(KIND_ENCODE, ones);
    send_request(KIND_DECODE, ones);
    send_request(KIND_DECODE, word_t'(63'h4));

    // Register values above the limit saturate at 57 data bits.
    write_data_bits(6'd63);
    send_request(KIND_ENCODE, ones);
    send_request(KIND_DECODE, word_t'(63'h7FFF_FFFF_FFFF_FFFE));

    // Random part: one phase per width, every fourth phase without gaps on
    // either side, and now and then a full drain of the codec.
    for (int unsigned phase = 0; phase < 13; phase++) begin
      if (phase < 12) write_data_bits(phase_widths[phase]);
      else write_data_bits(pos_t'($urandom_range(1, MAX_DATA_BITS)));
      calm    = (phase % 4 == 3);
      n_items = 120;
      for (int unsigned k = 0; k < n_items; k++) begin
        random_request();
        if ($urandom_range(0, 99) == 0) drain_codec();
      end
    end

    calm = 1'b0;
    drain_codec();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
